// ----- src/hssc_pkg.sv -----
// Package for the half-step stepper controller.
// Field widths, mode codes, coil pattern and speed tables; no dependencies.
package hssc_pkg;

    localparam int unsigned MODE_W  = 2;
    localparam int unsigned DEG_W   = 20;
    localparam int unsigned LVL_W   = 8;
    localparam int unsigned COILS_W = 4;
    localparam int unsigned STEPS_W = 24;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned SPEED_W = 3;

    localparam int unsigned STEPS_PER_REV_DEF = 4096;
    localparam int unsigned TICK_HZ_DEF       = 1000000;

    localparam int unsigned SPEED_LEVELS = 5;
    localparam int unsigned DEG_DIV      = 360;
    localparam int unsigned PRE_SHIFT    = 3;
    localparam int unsigned DIV_ODD      = DEG_DIV >> PRE_SHIFT;

    localparam logic [STEPS_W-1:0] STEP_MAX = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 2'd0,
        MODE_START = 2'd1,
        MODE_STOP  = 2'd2
    } t_mode;

    localparam int unsigned SPEED_HZ [SPEED_LEVELS] = '{900, 950, 1500, 1800, 2100};

    localparam logic [COILS_W-1:0] COIL_PATTERN [2**PHASE_W] = '{
        4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
    };

endpackage

// ----- src/hssc_if.sv -----
// Valid/ready channels for requests and results of the stepper controller.
// Depends on hssc_pkg for field widths.
interface hssc_req_if;
    logic                            valid;
    logic                            ready;
    logic [hssc_pkg::MODE_W-1:0]     mode;
    logic [hssc_pkg::DEG_W-1:0]      degrees;
    logic                            dir_ccw;
    logic [hssc_pkg::LVL_W-1:0]      speed_level;

    modport source (output valid, mode, degrees, dir_ccw, speed_level, input ready);
    modport sink   (input valid, mode, degrees, dir_ccw, speed_level, output ready);
endinterface

interface hssc_res_if;
    logic                            valid;
    logic                            ready;
    logic [hssc_pkg::COILS_W-1:0]    coils;
    logic                            step_taken;
    logic                            busy_res;
    logic [hssc_pkg::STEPS_W-1:0]    steps_remaining;

    modport source (output valid, coils, step_taken, busy_res, steps_remaining, input ready);
    modport sink   (input valid, coils, step_taken, busy_res, steps_remaining, output ready);
endinterface

// ----- src/half_step_stepper_controller.sv -----
// Half-step stepper controller: 8-phase drive with step timer and degree conversion.
// A request is registered in the input stage and then in the result stage.
// One request per cycle unless results stall; the degree product is formed on acceptance.
// Reset: synchronous active-low i_rst_n empties both stages and returns the motor
// state to idle, clockwise, speed level 1, phase 0, no steps, coils off.
// Depends on hssc_pkg and hssc_if.
module half_step_stepper_controller #(
    parameter int unsigned STEPS_PER_REV = hssc_pkg::STEPS_PER_REV_DEF,
    parameter int unsigned TICK_HZ       = hssc_pkg::TICK_HZ_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hssc_req_if.sink   i_req,
    hssc_res_if.source o_res
);

    localparam int unsigned SPR_W    = $clog2(STEPS_PER_REV + 1);
    localparam int unsigned PROD_W   = hssc_pkg::DEG_W + SPR_W;
    localparam int unsigned CMP_W    = (PROD_W > 34) ? PROD_W : 34;
    localparam int unsigned ODD_W    = $clog2(hssc_pkg::DIV_ODD);
    localparam int unsigned QX_W     = hssc_pkg::STEPS_W + ODD_W;
    localparam int unsigned RECIP_SH = QX_W + ODD_W;
    localparam int unsigned RECIP_W  = RECIP_SH - ODD_W + 1;
    localparam int unsigned MUL_W    = QX_W + RECIP_W;
    localparam longint unsigned RECIP_L =
        ((64'd1 << RECIP_SH) + 64'(hssc_pkg::DIV_ODD) - 64'd1) / 64'(hssc_pkg::DIV_ODD);
    localparam longint unsigned SAT_L = 64'(hssc_pkg::DEG_DIV) << hssc_pkg::STEPS_W;
    localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_L);
    localparam logic [CMP_W-1:0]   SAT_LIMIT = CMP_W'(SAT_L);

    localparam int unsigned PER_W = $clog2(TICK_HZ / hssc_pkg::SPEED_HZ[0] + 1);
    localparam logic [PER_W-1:0] PERIOD [hssc_pkg::SPEED_LEVELS] = '{
        PER_W'(TICK_HZ / hssc_pkg::SPEED_HZ[0]),
        PER_W'(TICK_HZ / hssc_pkg::SPEED_HZ[1]),
        PER_W'(TICK_HZ / hssc_pkg::SPEED_HZ[2]),
        PER_W'(TICK_HZ / hssc_pkg::SPEED_HZ[3]),
        PER_W'(TICK_HZ / hssc_pkg::SPEED_HZ[4])
    };
    localparam logic [hssc_pkg::SPEED_W-1:0] SPEED_TOP =
        hssc_pkg::SPEED_W'(hssc_pkg::SPEED_LEVELS - 1);

    // input stage
    logic                          r_in_valid;
    logic [hssc_pkg::MODE_W-1:0]   r_mode;
    logic                          r_dir_in;
    logic [hssc_pkg::LVL_W-1:0]    r_lvl;
    logic [PROD_W-1:0]             r_prod;

    // motor state
    logic                          r_busy,    n_busy;
    logic                          r_dir,     n_dir;
    logic [hssc_pkg::SPEED_W-1:0]  r_speed,   n_speed;
    logic [hssc_pkg::PHASE_W-1:0]  r_phase,   n_phase;
    logic [hssc_pkg::STEPS_W-1:0]  r_steps,   n_steps;
    logic [PER_W-1:0]              r_cnt,     n_cnt;
    logic                          r_driven,  n_driven;
    logic                          n_stepped;

    // result stage
    logic                          r_out_valid;
    logic [hssc_pkg::COILS_W-1:0]  r_coils;
    logic                          r_step_taken;
    logic                          r_busy_res;
    logic [hssc_pkg::STEPS_W-1:0]  r_steps_res;

    logic                          w_adv;
    logic [CMP_W-1:0]              w_prod_ext;
    logic [QX_W-1:0]               w_x;
    logic [MUL_W-1:0]              w_mul;
    logic [hssc_pkg::STEPS_W-1:0]  w_conv;
    logic [hssc_pkg::SPEED_W-1:0]  w_speed_idx;
    logic [PER_W-1:0]              w_cnt_inc;

    assign w_adv       = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || w_adv;

    // degrees * STEPS_PER_REV / 360 via divide by 8 then reciprocal of 45
    assign w_prod_ext = CMP_W'(r_prod);
    assign w_x        = QX_W'(w_prod_ext >> hssc_pkg::PRE_SHIFT);
    assign w_mul      = MUL_W'(w_x) * MUL_W'(RECIP);
    assign w_conv     = (w_prod_ext >= SAT_LIMIT) ? hssc_pkg::STEP_MAX
                                                  : w_mul[RECIP_SH +: hssc_pkg::STEPS_W];

    always_comb begin
        if (r_lvl == '0) begin
            w_speed_idx = '0;
        end else if (r_lvl > hssc_pkg::LVL_W'(hssc_pkg::SPEED_LEVELS)) begin
            w_speed_idx = SPEED_TOP;
        end else begin
            w_speed_idx = hssc_pkg::SPEED_W'(r_lvl - hssc_pkg::LVL_W'(1));
        end
    end

    assign w_cnt_inc = r_cnt + PER_W'(1);

    always_comb begin
        n_busy    = r_busy;
        n_dir     = r_dir;
        n_speed   = r_speed;
        n_phase   = r_phase;
        n_steps   = r_steps;
        n_cnt     = r_cnt;
        n_driven  = r_driven;
        n_stepped = 1'b0;
        unique case (hssc_pkg::t_mode'(r_mode))
            hssc_pkg::MODE_TICK: begin
                if (r_busy) begin
                    if (r_steps == '0) begin
                        n_busy = 1'b0;
                    end else if (w_cnt_inc >= PERIOD[r_speed]) begin
                        n_cnt     = '0;
                        n_phase   = r_dir ? r_phase - hssc_pkg::PHASE_W'(1)
                                          : r_phase + hssc_pkg::PHASE_W'(1);
                        n_driven  = 1'b1;
                        n_steps   = r_steps - hssc_pkg::STEPS_W'(1);
                        n_stepped = 1'b1;
                    end else begin
                        n_cnt = w_cnt_inc;
                    end
                end
            end
            hssc_pkg::MODE_START: begin
                if (!r_busy) begin
                    n_dir   = r_dir_in;
                    n_speed = w_speed_idx;
                    n_steps = w_conv;
                    n_busy  = 1'b1;
                    n_cnt   = '0;
                end
            end
            hssc_pkg::MODE_STOP: begin
                n_steps = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_busy      <= 1'b0;
            r_dir       <= 1'b0;
            r_speed     <= '0;
            r_phase     <= '0;
            r_steps     <= '0;
            r_cnt       <= '0;
            r_driven    <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_busy      <= n_busy;
                r_dir       <= n_dir;
                r_speed     <= n_speed;
                r_phase     <= n_phase;
                r_steps     <= n_steps;
                r_cnt       <= n_cnt;
                r_driven    <= n_driven;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_mode   <= i_req.mode;
            r_dir_in <= i_req.dir_ccw;
            r_lvl    <= i_req.speed_level;
            r_prod   <= PROD_W'(i_req.degrees) * PROD_W'(STEPS_PER_REV);
        end
        if (w_adv) begin
            r_coils      <= n_driven ? hssc_pkg::COIL_PATTERN[n_phase] : '0;
            r_step_taken <= n_stepped;
            r_busy_res   <= n_busy;
            r_steps_res  <= n_steps;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.coils           = r_coils;
    assign o_res.step_taken      = r_step_taken;
    assign o_res.busy_res        = r_busy_res;
    assign o_res.steps_remaining = r_steps_res;

endmodule

// ----- src/hssc_checker.sv -----
// Port-level checks for the half-step stepper controller, bound to the top level.
// Depends on hssc_pkg and half_step_stepper_controller.
module hssc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_res_valid,
    input logic                           i_res_ready,
    input logic [hssc_pkg::COILS_W-1:0]   i_coils,
    input logic                           i_step_taken,
    input logic                           i_busy_res,
    input logic [hssc_pkg::STEPS_W-1:0]   i_steps_remaining
);

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_coils)
            && $stable(i_step_taken) && $stable(i_busy_res) && $stable(i_steps_remaining))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_step_taken |-> i_busy_res)
        else $error("step reported while idle");

    a_step_coils: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_step_taken |-> i_coils != '0)
        else $error("step reported with coils off");

endmodule

bind half_step_stepper_controller hssc_checker u_hssc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_res_valid       (o_res.valid),
    .i_res_ready       (o_res.ready),
    .i_coils           (o_res.coils),
    .i_step_taken      (o_res.step_taken),
    .i_busy_res        (o_res.busy_res),
    .i_steps_remaining (o_res.steps_remaining)
);
